### rtl/core/pasm_pkg.sv
`default_nettype none

package pasm_pkg;

    localparam int MAX_DEGREE = 31;

    localparam int DEG_W      = 5;
    localparam int POW_W      = 6;
    localparam int COEF_W     = 16;
    localparam int TERM_W     = 32;
    localparam int RES_W      = 48;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;
    localparam int MODE_W     = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_OP_MODE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEGREE_A = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEGREE_B = 2'd2;

    // Operation modes; any other code multiplies.
    localparam logic [MODE_W-1:0] MODE_ADD = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SUB = 2'd1;
    localparam logic [MODE_W-1:0] MODE_MUL = 2'd2;

    typedef struct packed {
        logic                     operand_sel;
        logic [DEG_W-1:0]         power;
        logic signed [COEF_W-1:0] coef_value;
        logic                     load_done;
    } t_in_item;

    typedef struct packed {
        logic [POW_W-1:0]        result_power;
        logic signed [RES_W-1:0] result_value;
        logic                    result_last;
    } t_out_item;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;      // write the input beat into its store
        logic start;     // first result power, clear accumulator
        logic issue;     // form one term and advance the term index
        logic capture;   // latch the finished coefficient into the result register
        logic next_pow;  // move to the next result power
        logic clear;     // drop both stores
    } t_cmd;

    typedef struct packed {
        logic term_last;
        logic pow_last;
    } t_stat;

endpackage

`default_nettype wire

### rtl/core/pasm_ctrl.sv
`default_nettype none

module pasm_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    input  wire logic          i_load_done,
    input  wire logic          i_out_stall,
    input  wire pasm_pkg::t_stat i_stat,
    output pasm_pkg::t_cmd     o_cmd,
    output logic               o_in_stall,
    output logic               o_out_valid
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_STEP  = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;
    localparam logic [1:0] S_EMIT  = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_load_done) begin
                        o_cmd.start = 1'b1;
                        n_state     = S_STEP;
                    end
                end
            end
            S_STEP: begin
                o_cmd.issue = 1'b1;
                if (i_stat.term_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                // The last term is still in flight; fold it in while capturing.
                o_cmd.capture = 1'b1;
                n_state       = S_EMIT;
            end
            S_EMIT: begin
                if (!i_out_stall) begin
                    if (i_stat.pow_last) begin
                        o_cmd.clear = 1'b1;
                        n_state     = S_IDLE;
                    end else begin
                        o_cmd.next_pow = 1'b1;
                        n_state        = S_STEP;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = (r_state == S_EMIT);

endmodule

`default_nettype wire

### rtl/core/pasm_datapath.sv
`default_nettype none

module pasm_datapath #(
    parameter int MAX_DEGREE = pasm_pkg::MAX_DEGREE
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic [pasm_pkg::CFG_IDX_W-1:0]      i_cfg_addr,
    input  wire logic [pasm_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    input  wire pasm_pkg::t_in_item                  i_in_data,
    input  wire pasm_pkg::t_cmd                      i_cmd,
    output pasm_pkg::t_stat                          o_stat,
    output pasm_pkg::t_out_item                      o_out_data
);

    localparam int DEPTH = MAX_DEGREE + 1;
    localparam int IW    = (DEPTH > 2) ? $clog2(DEPTH) : 1;
    localparam int DW    = pasm_pkg::DEG_W;
    localparam int PW    = pasm_pkg::POW_W;
    localparam int CW    = pasm_pkg::COEF_W;
    localparam int TW    = pasm_pkg::TERM_W;
    localparam int RW    = pasm_pkg::RES_W;
    localparam logic [DW-1:0] MAX_DEG = DW'(MAX_DEGREE);

    // Configuration registers.
    logic [pasm_pkg::MODE_W-1:0] r_op_mode;
    logic [DW-1:0]               r_degree_a;
    logic [DW-1:0]               r_degree_b;

    // Coefficient stores; an entry without its valid bit reads as zero.
    logic [CW-1:0]    r_st_a [DEPTH];
    logic [CW-1:0]    r_st_b [DEPTH];
    logic [DEPTH-1:0] r_vld_a;
    logic [DEPTH-1:0] r_vld_b;

    logic [PW-1:0]        r_p;
    logic [IW-1:0]        r_i;
    logic signed [TW-1:0] r_term;
    logic                 r_term_vld;
    logic signed [RW-1:0] r_acc;
    logic [PW-1:0]        r_res_power;
    logic signed [RW-1:0] r_res_value;
    logic                 r_res_last;

    logic                 mul_mode;
    logic                 sub_mode;
    logic [DW-1:0]        deg_a;
    logic [DW-1:0]        deg_b;
    logic [PW-1:0]        deg_a6;
    logic [PW-1:0]        deg_b6;
    logic [PW-1:0]        i6;
    logic [PW-1:0]        j6;
    logic [PW-1:0]        hi6;
    logic [PW-1:0]        top_pow;
    logic [PW-1:0]        p_nx;
    logic [PW-1:0]        lo_nx;
    logic [IW-1:0]        addr_a;
    logic [IW-1:0]        addr_b;
    logic                 ok_a;
    logic                 ok_b;
    logic signed [CW-1:0] coef_a;
    logic signed [CW-1:0] coef_b;
    logic signed [CW:0]   lin;
    logic signed [TW-1:0] prod;
    logic signed [TW-1:0] term;
    logic signed [RW-1:0] acc_sum;
    logic [IW-1:0]        wr_idx;

    assign mul_mode = !(r_op_mode == pasm_pkg::MODE_ADD || r_op_mode == pasm_pkg::MODE_SUB);
    assign sub_mode = (r_op_mode == pasm_pkg::MODE_SUB);

    assign deg_a  = (r_degree_a > MAX_DEG) ? MAX_DEG : r_degree_a;
    assign deg_b  = (r_degree_b > MAX_DEG) ? MAX_DEG : r_degree_b;
    assign deg_a6 = {1'b0, deg_a};
    assign deg_b6 = {1'b0, deg_b};

    // Term index i walks A, j = p - i walks B; the walk is bounded so both stay in range.
    assign i6  = {{(PW-IW){1'b0}}, r_i};
    assign j6  = r_p - i6;
    assign hi6 = (r_p < deg_a6) ? r_p : deg_a6;

    assign top_pow = mul_mode ? (deg_a6 + deg_b6) : ((deg_a6 > deg_b6) ? deg_a6 : deg_b6);
    assign p_nx    = r_p + PW'(1);
    assign lo_nx   = (p_nx > deg_b6) ? (p_nx - deg_b6) : '0;

    assign addr_a = mul_mode ? r_i : r_p[IW-1:0];
    assign addr_b = mul_mode ? j6[IW-1:0] : r_p[IW-1:0];
    assign ok_a   = mul_mode || (r_p <= deg_a6);
    assign ok_b   = mul_mode || (r_p <= deg_b6);

    assign coef_a = (ok_a && r_vld_a[addr_a]) ? r_st_a[addr_a] : '0;
    assign coef_b = (ok_b && r_vld_b[addr_b]) ? r_st_b[addr_b] : '0;

    assign lin  = sub_mode ? ({coef_a[CW-1], coef_a} - {coef_b[CW-1], coef_b})
                           : ({coef_a[CW-1], coef_a} + {coef_b[CW-1], coef_b});
    assign prod = $signed({{(TW-CW){coef_a[CW-1]}}, coef_a})
                * $signed({{(TW-CW){coef_b[CW-1]}}, coef_b});
    assign term = mul_mode ? prod : {{(TW-CW-9){lin[CW]}}, lin, 8'd0};

    assign acc_sum = r_term_vld ? (r_acc + {{(RW-TW){r_term[TW-1]}}, r_term}) : r_acc;

    assign o_stat.term_last = mul_mode ? (i6 == hi6) : 1'b1;
    assign o_stat.pow_last  = (r_p == top_pow);

    assign wr_idx = i_in_data.power[IW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op_mode  <= pasm_pkg::MODE_ADD;
            r_degree_a <= '0;
            r_degree_b <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                pasm_pkg::CFG_OP_MODE:  r_op_mode  <= i_cfg_wdata[pasm_pkg::MODE_W-1:0];
                pasm_pkg::CFG_DEGREE_A: r_degree_a <= i_cfg_wdata[DW-1:0];
                pasm_pkg::CFG_DEGREE_B: r_degree_b <= i_cfg_wdata[DW-1:0];
                default: begin
                end
            endcase
        end
    end

    // Loads beyond the operand's degree are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_a <= '0;
            r_vld_b <= '0;
        end else if (i_cmd.clear) begin
            r_vld_a <= '0;
            r_vld_b <= '0;
        end else if (i_cmd.load) begin
            if (!i_in_data.operand_sel && i_in_data.power <= deg_a) begin
                r_vld_a[wr_idx] <= 1'b1;
            end
            if (i_in_data.operand_sel && i_in_data.power <= deg_b) begin
                r_vld_b[wr_idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            if (!i_in_data.operand_sel && i_in_data.power <= deg_a) begin
                r_st_a[wr_idx] <= i_in_data.coef_value;
            end
            if (i_in_data.operand_sel && i_in_data.power <= deg_b) begin
                r_st_b[wr_idx] <= i_in_data.coef_value;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_term_vld <= 1'b0;
        end else begin
            r_term_vld <= i_cmd.issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.issue) begin
            r_term <= term;
        end
        if (i_cmd.start) begin
            r_p   <= '0;
            r_i   <= '0;
            r_acc <= '0;
        end else if (i_cmd.next_pow) begin
            r_p   <= p_nx;
            r_i   <= lo_nx[IW-1:0];
            r_acc <= '0;
        end else begin
            r_acc <= acc_sum;
            if (i_cmd.issue) begin
                r_i <= r_i + IW'(1);
            end
        end
        if (i_cmd.capture) begin
            r_res_power <= r_p;
            r_res_value <= acc_sum;
            r_res_last  <= o_stat.pow_last;
        end
    end

    assign o_out_data.result_power = r_res_power;
    assign o_out_data.result_value = r_res_value;
    assign o_out_data.result_last  = r_res_last;

endmodule

`default_nettype wire

### rtl/core/polynomial_add_sub_mul.sv
`default_nettype none

// Polynomial add, subtract and multiply engine. Coefficients of A and B arrive one per beat,
// each tagged with operand and power, in signed Q8.8; the beat marked load_done starts the
// job, and the block then sends one signed Q32.16 coefficient per power in ascending order,
// with result_last on the highest. Add and subtract send max(degree_a, degree_b) + 1 beats,
// multiply sends degree_a + degree_b + 1. Both stores are empty again after each job.
// After the final beat, the single multiply-accumulate unit forms one term per cycle; for
// each result coefficient it issues all its terms, folds the last one in while capturing
// the result, then holds that result until the output is not stalled. No input is taken
// meanwhile. The user must write configuration only while the block is idle; the block
// itself does not enforce this.
module polynomial_add_sub_mul #(
    parameter int MAX_DEGREE = pasm_pkg::MAX_DEGREE
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [pasm_pkg::CFG_IDX_W-1:0]  i_cfg_addr,
    input  wire logic [pasm_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    input  wire logic                            i_in_valid,
    input  wire pasm_pkg::t_in_item              i_in_data,
    output logic                                 o_in_stall,
    output logic                                 o_out_valid,
    output pasm_pkg::t_out_item                  o_out_data,
    input  wire logic                            i_out_stall
);

    pasm_pkg::t_cmd  cmd;
    pasm_pkg::t_stat stat;

    pasm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_load_done (i_in_data.load_done),
        .i_out_stall (i_out_stall),
        .i_stat      (stat),
        .o_cmd       (cmd),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid)
    );

    pasm_datapath #(
        .MAX_DEGREE (MAX_DEGREE)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire
